// ===== sv/sstq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
`timescale 1ns / 1ps
package sstq_pkg;

    // Action codes
    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_FREE  = 3'd1;
    localparam logic [2:0] ACT_BIND  = 3'd2;
    localparam logic [2:0] ACT_START = 3'd3;
    localparam logic [2:0] ACT_TICK  = 3'd4;

    // Slot status codes
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // Result kinds
    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

    // Sequencer states
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ASCAN   = 9'b000000010,
        S_LRD     = 9'b000000100,
        S_LCHK    = 9'b000001000,
        S_URD     = 9'b000010000,
        S_UCHK    = 9'b000100000,
        S_TRD     = 9'b001000000,
        S_TCHK    = 9'b010000000,
        S_HEAD    = 9'b100000000
    } t_state;

endpackage

// ===== sv/sorted_software_timer_queue_top.sv =====
// Top level of the sorted timer queue: sequencer, status bits and list registers.
// Allocate: reply strobed from S_ASCAN; bind writes queue and word when accepted.
// Start reads and compares each list entry in S_LRD and S_LCHK; free walks the list in S_UCHK.
// Tick: expiries are reported one by one, each held until the next entry is checked.
// One transaction at a time; the record memory walk sets the time.
// Reset (synchronous, active low) frees all slots and empties the list; records stay.
`timescale 1ns / 1ps
module sorted_software_timer_queue_top #(
    parameter int NUM_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [4:0]  i_slot_id,
    input  logic [7:0]  i_dest_queue,
    input  logic [31:0] i_event_word,
    input  logic [31:0] i_delay_ticks,
    output logic        o_strobe,
    output logic        o_result_kind,
    output logic [4:0]  o_out_slot,
    output logic        o_granted,
    output logic [7:0]  o_out_queue,
    output logic [31:0] o_out_word,
    output logic        o_last
);
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    sstq_pkg::t_state r_state, n_state;
    logic [1:0]    r_status [NUM_SLOTS];
    logic [31:0]   r_tick, r_near;
    logic [CW-1:0] r_total, r_j;
    logic [AW-1:0] r_head, r_prev, r_cur, r_slot;
    logic [31:0]   r_dl;
    // flags: 0 free at head, 1 read in flight, 2 expiry held, 3 second link pending
    logic [3:0]    r_scan;

    // Memory ports
    logic [AW-1:0] m_raddr, m_waddr, m_wsucc, m_rsucc;
    logic [31:0]   m_rdl, m_rw, m_wdl;
    logic [7:0]    m_rq;
    logic          m_we_dl, m_we_succ, m_we_qw;

    sstq_mem #(.AW(AW)) u_mem (
        .i_clk(i_clk), .i_raddr(m_raddr), .o_rdl(m_rdl), .o_rsucc(m_rsucc),
        .o_rq(m_rq), .o_rw(m_rw), .i_we_dl(m_we_dl), .i_we_succ(m_we_succ),
        .i_we_qw(m_we_qw), .i_waddr(m_waddr), .i_wdl(m_wdl), .i_wsucc(m_wsucc),
        .i_wq(i_dest_queue), .i_ww(i_event_word)
    );

    logic acc, slot_ok;
    assign busy    = (r_state != sstq_pkg::S_IDLE);
    assign acc     = start && !busy;
    assign slot_ok = (7'(i_slot_id) < 7'(NUM_SLOTS));
    logic [AW-1:0] in_slot;
    assign in_slot = AW'(i_slot_id);

    // Expiry walk: data for r_cur is valid when no read is in flight
    logic due;
    assign due = (m_rdl <= r_tick);

    // Memory control, read address and sequencer next state
    always_comb begin
        n_state   = r_state;
        m_raddr   = r_cur;
        m_waddr   = r_slot;
        m_wdl     = r_dl;
        m_wsucc   = r_cur;
        m_we_dl   = 1'b0;
        m_we_succ = 1'b0;
        m_we_qw   = 1'b0;
        case (r_state)
            sstq_pkg::S_IDLE: begin
                m_raddr = r_head;
                m_waddr = in_slot;
                m_wdl   = r_tick + i_delay_ticks;
                if (acc) begin
                    case (i_action)
                        sstq_pkg::ACT_ALLOC: n_state = sstq_pkg::S_ASCAN;
                        sstq_pkg::ACT_BIND:  m_we_qw = slot_ok;
                        sstq_pkg::ACT_FREE: begin
                            if (slot_ok && r_status[in_slot] == sstq_pkg::ST_RUN
                                && r_total != '0)
                                n_state = (in_slot == r_head) ? sstq_pkg::S_HEAD
                                                              : sstq_pkg::S_URD;
                        end
                        sstq_pkg::ACT_START: begin
                            if (slot_ok && r_status[in_slot] != sstq_pkg::ST_RUN) begin
                                m_we_dl = 1'b1;
                                n_state = sstq_pkg::S_LRD;
                            end
                        end
                        sstq_pkg::ACT_TICK: begin
                            if (r_near <= r_tick + 32'd1) n_state = sstq_pkg::S_TCHK;
                        end
                        default: ;
                    endcase
                end
            end
            sstq_pkg::S_ASCAN: n_state = sstq_pkg::S_IDLE;
            // Insertion: r_cur read issued, r_prev its predecessor
            sstq_pkg::S_LRD: begin
                m_raddr = r_cur;
                n_state = sstq_pkg::S_LCHK;
            end
            sstq_pkg::S_LCHK: begin
                if (r_total == CW'(1)) begin
                    n_state = sstq_pkg::S_IDLE;
                end else if (r_j == '0) begin
                    // compare with head
                    if (r_dl <= m_rdl) begin
                        m_wsucc = r_head; m_we_succ = 1'b1;
                        n_state = sstq_pkg::S_IDLE;
                    end else if (r_total == CW'(2)) begin
                        m_waddr = r_head; m_wsucc = r_slot; m_we_succ = 1'b1;
                        n_state = sstq_pkg::S_IDLE;
                    end else begin
                        m_raddr = m_rsucc;
                        n_state = sstq_pkg::S_LRD;
                    end
                end else if (r_dl <= m_rdl) begin
                    m_waddr = r_prev; m_wsucc = r_slot; m_we_succ = 1'b1;
                    n_state = sstq_pkg::S_HEAD; // second write follows
                end else if (r_j + CW'(2) >= r_total) begin
                    m_waddr = r_cur; m_wsucc = r_slot; m_we_succ = 1'b1;
                    n_state = sstq_pkg::S_IDLE;
                end else begin
                    n_state = sstq_pkg::S_LRD;
                end
            end
            // Shared finishing step: insert second link or free-at-head
            sstq_pkg::S_HEAD: begin
                if (r_scan[3]) begin
                    // r_prev now holds the entry the new timer goes before
                    m_waddr = r_slot; m_wsucc = r_prev; m_we_succ = 1'b1;
                    n_state = sstq_pkg::S_IDLE;
                end else begin
                    m_raddr = r_head;
                    n_state = sstq_pkg::S_UCHK;
                end
            end
            // Unlink walk
            sstq_pkg::S_URD: begin
                m_raddr = r_cur;
                n_state = sstq_pkg::S_UCHK;
            end
            sstq_pkg::S_UCHK: begin
                if (r_j == '1 || r_scan[0]) begin
                    // head removal: m_rsucc is head's successor, m_rdl head deadline
                    n_state = sstq_pkg::S_TRD;
                    m_raddr = m_rsucc;
                end else if (m_rsucc == r_slot) begin
                    m_raddr = r_slot;
                    n_state = sstq_pkg::S_TRD;
                end else if (r_j + CW'(1) >= r_total) begin
                    n_state = sstq_pkg::S_IDLE;
                end else begin
                    m_raddr = m_rsucc;
                    n_state = sstq_pkg::S_UCHK;
                end
            end
            sstq_pkg::S_TRD: begin
                if (r_scan[0]) begin
                    n_state = sstq_pkg::S_IDLE;
                end else begin
                    m_waddr = r_prev; m_wsucc = m_rsucc; m_we_succ = 1'b1;
                    n_state = sstq_pkg::S_IDLE;
                end
            end
            // Tick expiry walk: r_cur is read every cycle
            sstq_pkg::S_TCHK: begin
                m_raddr = r_cur;
                if (!r_scan[1] && !r_scan[2] && !(r_j != '0 && due))
                    n_state = sstq_pkg::S_IDLE;
            end
            default: n_state = sstq_pkg::S_IDLE;
        endcase
    end

    // Allocation search (combinational priority over status bits)
    logic          fr_found;
    logic [AW-1:0] fr_idx;
    always_comb begin
        fr_found = 1'b0;
        fr_idx   = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_status[k] == sstq_pkg::ST_FREE) begin
                fr_found = 1'b1;
                fr_idx   = AW'(k);
            end
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_state <= sstq_pkg::S_IDLE;
            r_tick  <= '0;
            r_near  <= sstq_pkg::NO_DEADLINE;
            r_total <= '0;
            r_head  <= '0;
            r_scan  <= '0;
            r_j     <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) r_status[k] <= sstq_pkg::ST_FREE;
        end else begin
            r_state <= n_state;
            case (r_state)
                sstq_pkg::S_IDLE: if (acc) begin
                    r_slot <= in_slot;
                    r_dl   <= r_tick + i_delay_ticks;
                    r_cur  <= r_head;
                    r_prev <= r_head;
                    r_j    <= '0;
                    r_scan <= '0;
                    case (i_action)
                        sstq_pkg::ACT_FREE: if (slot_ok) begin
                            r_status[in_slot] <= sstq_pkg::ST_FREE;
                            if (r_status[in_slot] == sstq_pkg::ST_RUN
                                && r_total != '0) begin
                                r_scan[0] <= (in_slot == r_head);
                                r_j <= CW'(1);
                            end
                        end
                        sstq_pkg::ACT_START:
                            if (slot_ok && r_status[in_slot] != sstq_pkg::ST_RUN) begin
                                r_status[in_slot] <= sstq_pkg::ST_RUN;
                                r_total <= r_total + CW'(1);
                                if (r_total == '0) begin
                                    r_head <= in_slot;
                                    r_near <= r_tick + i_delay_ticks;
                                end
                            end
                        sstq_pkg::ACT_TICK: begin
                            r_tick <= r_tick + 32'd1;
                            r_j    <= r_total;
                            r_scan[1] <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                sstq_pkg::S_ASCAN: begin
                    o_strobe      <= 1'b1;
                    o_result_kind <= sstq_pkg::KIND_ALLOC;
                    o_out_slot    <= fr_found ? 5'(fr_idx) : 5'd0;
                    o_granted     <= fr_found;
                    o_out_queue   <= '0;
                    o_out_word    <= '0;
                    o_last        <= 1'b1;
                    if (fr_found) r_status[fr_idx] <= sstq_pkg::ST_ALLOC;
                end
                sstq_pkg::S_LCHK: begin
                    if (r_total != CW'(1) && r_j == '0 && r_dl <= m_rdl) begin
                        r_head <= r_slot;
                        r_near <= r_dl;
                    end
                    if (r_j != '0 && r_dl <= m_rdl) r_scan[3] <= 1'b1;
                    r_prev <= r_cur;
                    r_cur  <= m_rsucc;
                    r_j    <= r_j + CW'(1);
                end
                sstq_pkg::S_HEAD: r_scan[3] <= 1'b0;
                sstq_pkg::S_UCHK: begin
                    if (r_scan[0]) begin
                        r_head  <= m_rsucc;
                        r_total <= r_total - CW'(1);
                        if (r_total == CW'(1)) r_near <= sstq_pkg::NO_DEADLINE;
                    end else if (m_rsucc == r_slot) begin
                        r_total <= r_total - CW'(1);
                    end else begin
                        r_prev <= m_rsucc;
                        r_j    <= r_j + CW'(1);
                    end
                end
                sstq_pkg::S_TRD: if (r_scan[0] && r_total != '0) r_near <= m_rdl;
                sstq_pkg::S_TCHK: begin
                    if (r_scan[1]) begin
                        // read of r_cur in flight
                        r_scan[1] <= 1'b0;
                    end else if (r_scan[2]) begin
                        // release the held expiry; last unless the next entry is due
                        o_strobe  <= 1'b1;
                        o_last    <= !(r_j != '0 && due);
                        r_scan[2] <= 1'b0;
                    end else if (r_j != '0 && due) begin
                        // hold this expiry until the next entry has been checked
                        o_result_kind <= sstq_pkg::KIND_EXPIRY;
                        o_out_slot    <= 5'(r_cur);
                        o_granted     <= 1'b0;
                        o_out_queue   <= m_rq;
                        o_out_word    <= m_rw;
                        r_status[r_cur] <= sstq_pkg::ST_ALLOC;
                        r_cur   <= m_rsucc;
                        r_head  <= m_rsucc;
                        r_total <= r_total - CW'(1);
                        r_j     <= r_j - CW'(1);
                        r_scan[1] <= 1'b1;
                        r_scan[2] <= 1'b1;
                    end else begin
                        r_near <= (r_j != '0) ? m_rdl : sstq_pkg::NO_DEADLINE;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== sv/sstq_mem.sv =====
// Slot record memory: deadline, successor, queue and word, one synchronous read port.
`timescale 1ns / 1ps
module sstq_mem #(
    parameter int AW = 5
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdl,
    output logic [AW-1:0] o_rsucc,
    output logic [7:0]    o_rq,
    output logic [31:0]   o_rw,
    input  logic          i_we_dl,
    input  logic          i_we_succ,
    input  logic          i_we_qw,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdl,
    input  logic [AW-1:0] i_wsucc,
    input  logic [7:0]    i_wq,
    input  logic [31:0]   i_ww
);
    localparam int DEPTH = 1 << AW;
    logic [31:0]   r_dl   [DEPTH];
    logic [AW-1:0] r_succ [DEPTH];
    logic [7:0]    r_q    [DEPTH];
    logic [31:0]   r_w    [DEPTH];

    // Writes
    always_ff @(posedge i_clk) begin
        if (i_we_dl) r_dl[i_waddr] <= i_wdl;
        if (i_we_succ) r_succ[i_waddr] <= i_wsucc;
        if (i_we_qw) begin
            r_q[i_waddr] <= i_wq;
            r_w[i_waddr] <= i_ww;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdl   <= r_dl[i_raddr];
        o_rsucc <= r_succ[i_raddr];
        o_rq    <= r_q[i_raddr];
        o_rw    <= r_w[i_raddr];
    end
endmodule

// ===== sv/sstq_checker.sv =====
// Port-level checks for the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps
module sstq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_result_kind,
    input logic o_granted,
    input logic o_last,
    input logic [2:0] i_action
);
    // An allocation reply is always a single final result
    a_alloc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result_kind == sstq_pkg::KIND_ALLOC |-> o_last)
        else $error("alloc reply malformed");
    // Expiry results never claim a grant
    a_exp_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result_kind == sstq_pkg::KIND_EXPIRY |-> !o_granted)
        else $error("expiry with grant");
    // Allocate makes the block busy next cycle
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_action == sstq_pkg::ACT_ALLOC |=> busy)
        else $error("allocate not taken");
    // Reset leaves the block idle
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("not idle after reset");
endmodule

bind sorted_software_timer_queue_top sstq_checker u_sstq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_result_kind(o_result_kind), .o_granted(o_granted),
    .o_last(o_last), .i_action(i_action)
);
